@@ hdl/pti_pkg.sv @@
// Package for the polynomial trapezoid integrator.
// Holds the item and result word types, status codes, controller states and datapath ops.
// No dependencies.
`timescale 1ns / 1ps

package pti_pkg;

  localparam int NUM_REGS = 8;
  localparam int ADDR_W   = 5;
  localparam int COEF_W   = 16;
  localparam int ACC_W    = 48;

  typedef enum logic [1:0] {
    STATUS_OK        = 2'd0,
    STATUS_ZERO_STEP = 2'd1,
    STATUS_SAT       = 2'd2
  } status_t;

  typedef struct packed {
    logic signed [15:0] start_x;
    logic signed [15:0] end_x;
    logic        [15:0] step_size;
  } in_word_t;

  typedef struct packed {
    logic signed [ACC_W-1:0] integral;
    logic        [1:0]       status;
  } out_word_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_LOAD,
    ST_HORNER,
    ST_ADVANCE,
    ST_AREA,
    ST_ACCUM,
    ST_FINISH
  } state_t;

  typedef enum logic [2:0] {
    OP_NOP,
    OP_CAPTURE,
    OP_H_LOAD,
    OP_H_STEP,
    OP_ADVANCE,
    OP_AREA_MUL,
    OP_ACCUM,
    OP_EMIT
  } dp_op_t;

  typedef struct packed {
    logic zero_step;
    logic fits;
    logic first;
    logic rem_zero;
    logic rem_last;
  } dp_stat_t;

endpackage

@@ hdl/pti_ctrl.sv @@
// Controller state machine of the polynomial trapezoid integrator.
// Sequences the datapath one op per cycle and owns both handshakes; uses pti_pkg.
`timescale 1ns / 1ps

module pti_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  output logic              item_ready,
  output logic              result_valid,
  input  logic              result_ready,
  input  pti_pkg::dp_stat_t stat,
  output pti_pkg::dp_op_t   op
);

  pti_pkg::state_t state, state_next;
  logic            emit;

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= pti_pkg::ST_IDLE;
      result_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (emit) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_comb begin
    state_next = state;
    op         = pti_pkg::OP_NOP;
    item_ready = 1'b0;
    emit       = 1'b0;
    unique case (state)
      pti_pkg::ST_IDLE: begin
        // No word is taken while reset is held.
        item_ready = !rst;
        if (item_valid && !rst) begin
          op         = pti_pkg::OP_CAPTURE;
          state_next = pti_pkg::ST_CHECK;
        end
      end
      pti_pkg::ST_CHECK: begin
        if (stat.zero_step || !stat.fits) begin
          state_next = pti_pkg::ST_FINISH;
        end else if (stat.first) begin
          state_next = pti_pkg::ST_LOAD;
        end else begin
          state_next = pti_pkg::ST_ADVANCE;
        end
      end
      pti_pkg::ST_ADVANCE: begin
        op         = pti_pkg::OP_ADVANCE;
        state_next = pti_pkg::ST_LOAD;
      end
      pti_pkg::ST_LOAD: begin
        op         = pti_pkg::OP_H_LOAD;
        state_next = pti_pkg::ST_HORNER;
      end
      pti_pkg::ST_HORNER: begin
        if (!stat.rem_zero) begin
          op = pti_pkg::OP_H_STEP;
        end
        if (stat.rem_zero || stat.rem_last) begin
          state_next = stat.first ? pti_pkg::ST_ADVANCE : pti_pkg::ST_AREA;
        end
      end
      pti_pkg::ST_AREA: begin
        op         = pti_pkg::OP_AREA_MUL;
        state_next = pti_pkg::ST_ACCUM;
      end
      pti_pkg::ST_ACCUM: begin
        op         = pti_pkg::OP_ACCUM;
        state_next = pti_pkg::ST_CHECK;
      end
      pti_pkg::ST_FINISH: begin
        if (!result_valid || result_ready) begin
          op         = pti_pkg::OP_EMIT;
          emit       = 1'b1;
          state_next = pti_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = pti_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

@@ hdl/pti_dp.sv @@
// Datapath of the polynomial trapezoid integrator: Horner unit, trapezoid area and accumulator.
// Driven by ops from pti_ctrl; uses pti_pkg.
`timescale 1ns / 1ps

module pti_dp #(
  parameter int NUM_COEFFS = 8
) (
  input  logic                                         clk,
  input  logic                                         rst,
  input  logic [NUM_COEFFS-1:0][pti_pkg::COEF_W-1:0]   coefs,
  input  pti_pkg::in_word_t                            item,
  input  pti_pkg::dp_op_t                              op,
  output pti_pkg::dp_stat_t                            stat,
  output pti_pkg::out_word_t                           result
);

  localparam int RW = (NUM_COEFFS > 1) ? $clog2(NUM_COEFFS) : 1;

  logic signed [15:0]              x;
  logic signed [15:0]              end_x;
  logic        [15:0]              step;
  logic signed [31:0]              h;
  logic signed [31:0]              fprev;
  logic signed [40:0]              area;
  logic signed [pti_pkg::ACC_W-1:0] acc;
  logic                            sat;
  logic                            first;
  logic        [RW-1:0]            rem;

  logic        [RW-1:0]            cidx;
  logic signed [15:0]              coef_sel;
  logic signed [15:0]              coef_top;
  logic signed [47:0]              hprod;
  logic signed [39:0]              hshift;
  logic                            mul_ovf;
  logic signed [31:0]              hmul;
  logic signed [32:0]              hsum;
  logic                            add_ovf;
  logic signed [31:0]              h_new;
  logic signed [32:0]              fsum;
  logic signed [49:0]              aprod;
  logic signed [48:0]              acc_sum;
  logic                            acc_ovf;
  logic signed [17:0]              x_right;

  // One Horner stage: multiply, floor shift, clamp, add the coefficient, clamp.
  assign cidx     = rem - RW'(1);
  assign coef_sel = $signed(coefs[cidx]);
  assign coef_top = $signed(coefs[NUM_COEFFS-1]);
  assign hprod    = h * x;
  assign hshift   = hprod[47:8];
  assign mul_ovf  = !((&hshift[39:31]) || !(|hshift[39:31]));
  assign hmul     = mul_ovf ? (hshift[39] ? 32'sh8000_0000 : 32'sh7FFF_FFFF) : hshift[31:0];
  assign hsum     = {hmul[31], hmul} + {{9{coef_sel[15]}}, coef_sel, 8'h00};
  assign add_ovf  = hsum[32] != hsum[31];
  assign h_new    = add_ovf ? (hsum[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF) : hsum[31:0];

  // Trapezoid area and accumulation.
  assign fsum    = {fprev[31], fprev} + {h[31], h};
  assign aprod   = fsum * $signed({1'b0, step});
  assign acc_sum = {acc[pti_pkg::ACC_W-1], acc} + {{8{area[40]}}, area};
  assign acc_ovf = acc_sum[48] != acc_sum[47];

  assign x_right = $signed({{2{x[15]}}, x}) + $signed({2'b00, step});

  assign stat.zero_step = (step == 16'h0000);
  assign stat.fits      = x_right <= $signed({{2{end_x[15]}}, end_x});
  assign stat.first     = first;
  assign stat.rem_zero  = (rem == '0);
  assign stat.rem_last  = (rem == RW'(1));

  always_ff @(posedge clk) begin
    if (rst) begin
      first <= 1'b0;
      rem   <= '0;
    end else begin
      unique case (op)
        pti_pkg::OP_CAPTURE: begin
          first <= 1'b1;
        end
        pti_pkg::OP_H_LOAD: begin
          rem <= RW'(NUM_COEFFS - 1);
        end
        pti_pkg::OP_H_STEP: begin
          rem <= rem - RW'(1);
        end
        pti_pkg::OP_ADVANCE: begin
          first <= 1'b0;
        end
        pti_pkg::OP_NOP, pti_pkg::OP_AREA_MUL, pti_pkg::OP_ACCUM, pti_pkg::OP_EMIT: begin
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (op)
      pti_pkg::OP_CAPTURE: begin
        x     <= item.start_x;
        end_x <= item.end_x;
        step  <= item.step_size;
        acc   <= '0;
        sat   <= 1'b0;
      end
      pti_pkg::OP_H_LOAD: begin
        h <= {{8{coef_top[15]}}, coef_top, 8'h00};
      end
      pti_pkg::OP_H_STEP: begin
        h <= h_new;
        if (mul_ovf || add_ovf) begin
          sat <= 1'b1;
        end
      end
      pti_pkg::OP_ADVANCE: begin
        x <= x_right[15:0];
        if (first) begin
          fprev <= h;
        end
      end
      pti_pkg::OP_AREA_MUL: begin
        area <= aprod[49:9];
      end
      pti_pkg::OP_ACCUM: begin
        fprev <= h;
        if (acc_ovf) begin
          sat <= 1'b1;
          acc <= acc_sum[48] ? {1'b1, {(pti_pkg::ACC_W-1){1'b0}}}
                             : {1'b0, {(pti_pkg::ACC_W-1){1'b1}}};
        end else begin
          acc <= acc_sum[pti_pkg::ACC_W-1:0];
        end
      end
      pti_pkg::OP_EMIT: begin
        result.integral <= acc;
        if (stat.zero_step) begin
          result.status <= pti_pkg::STATUS_ZERO_STEP;
        end else if (sat) begin
          result.status <= pti_pkg::STATUS_SAT;
        end else begin
          result.status <= pti_pkg::STATUS_OK;
        end
      end
      pti_pkg::OP_NOP: begin
      end
      default: begin
      end
    endcase
  end

endmodule

@@ hdl/poly_trapezoid_integrator.sv @@
// Top level of the polynomial trapezoid integrator.
// Holds the coefficient registers and APB port; instantiates pti_ctrl and pti_dp, uses pti_pkg.
`timescale 1ns / 1ps

// Usage
// An item word (start_x, end_x, step_size, Q8.8) enters on item_valid/item_ready.
// The block walks x from start_x in exact steps and sums the trapezoid areas of every
// whole interval that ends at or before end_x, then returns one result word (integral
// in Q32.16 and status) on result_valid/result_ready.
// Coefficients coef_0..coef_7 are written over the APB port at byte address 4*k; the
// user must write them only while the block is idle, which the block does not enforce.
// Coefficients at or above NUM_COEFFS stay zero. One item is worked on at a time. A
// zero step or an empty range goes from ST_CHECK straight to ST_FINISH. Otherwise the
// time per interval is set by the single Horner multiplier, which takes one coefficient
// per cycle; f at the right end of an interval is reused as the left value of the next.
// The block takes a new item in the cycle after its result word is loaded into the
// output register, so it can work while the last result is still waiting. If the
// receiver stalls, the finished result waits in the datapath, with the controller held
// in ST_FINISH, until the output register is free.
// Reset clears the coefficients to zero and drops both handshakes.

module poly_trapezoid_integrator #(
  parameter int NUM_COEFFS = 8
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        item_valid,
  output logic                        item_ready,
  input  pti_pkg::in_word_t           item,
  output logic                        result_valid,
  input  logic                        result_ready,
  output pti_pkg::out_word_t          result,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [pti_pkg::ADDR_W-1:0]  paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);

  // Only the first eight coefficients have registers; any above that read as zero.
  localparam int NUM_STORED = (NUM_COEFFS < pti_pkg::NUM_REGS) ? NUM_COEFFS
                                                               : pti_pkg::NUM_REGS;

  logic [pti_pkg::COEF_W-1:0]                  coef_q [NUM_STORED];
  logic [NUM_COEFFS-1:0][pti_pkg::COEF_W-1:0]  coefs;
  logic                                        wr_en;
  logic [2:0]                                  reg_idx;
  pti_pkg::dp_op_t                             op;
  pti_pkg::dp_stat_t                           stat;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;
  assign reg_idx = paddr[pti_pkg::ADDR_W-1:2];

  // Writes to an index without a register are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < NUM_STORED; k++) begin
        coef_q[k] <= '0;
      end
    end else if (wr_en) begin
      for (int k = 0; k < NUM_STORED; k++) begin
        if (reg_idx == 3'(k)) begin
          coef_q[k] <= pwdata[pti_pkg::COEF_W-1:0];
        end
      end
    end
  end

  // Reads return the coefficient sign-extended to the bus width.
  always_comb begin
    prdata = '0;
    for (int k = 0; k < NUM_STORED; k++) begin
      if (reg_idx == 3'(k)) begin
        prdata = {{(32-pti_pkg::COEF_W){coef_q[k][pti_pkg::COEF_W-1]}}, coef_q[k]};
      end
    end
  end

  for (genvar k = 0; k < NUM_COEFFS; k++) begin : g_coef
    if (k < NUM_STORED) begin : g_reg
      assign coefs[k] = coef_q[k];
    end else begin : g_zero
      assign coefs[k] = '0;
    end
  end

  pti_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .stat         (stat),
    .op           (op)
  );

  pti_dp #(
    .NUM_COEFFS (NUM_COEFFS)
  ) u_dp (
    .clk    (clk),
    .rst    (rst),
    .coefs  (coefs),
    .item   (item),
    .op     (op),
    .stat   (stat),
    .result (result)
  );

endmodule

@@ hdl/pti_checker.sv @@
// Port-level checker for the polynomial trapezoid integrator, bound to the top level.
// Uses pti_pkg; watches only the item and result channels.
`timescale 1ns / 1ps

module pti_checker (
  input logic               clk,
  input logic               rst,
  input logic               item_valid,
  input logic               item_ready,
  input logic               result_valid,
  input logic               result_ready,
  input pti_pkg::out_word_t result
);

  // A stalled result word holds still until it is taken.
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(result))
    else $error("result word changed or dropped while stalled");

  // A zero step never produces area.
  a_zero_step_empty: assert property (@(posedge clk) disable iff (rst)
    result_valid && (result.status == pti_pkg::STATUS_ZERO_STEP) |-> (result.integral == '0))
    else $error("zero step result carries a nonzero integral");

  // Once an item is taken the block is busy with it.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    item_valid && item_ready |=> !item_ready)
    else $error("item accepted while previous item still in work");

  // A new result only appears while the block is not taking items.
  a_result_from_busy: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> !$past(item_ready))
    else $error("result appeared without an item in work");

endmodule

bind poly_trapezoid_integrator pti_checker u_checker (.*);
